[sv/ipd_pkg.sv]
`timescale 1ns / 1ps

package ipd_pkg;

   localparam int TICKS_W = 17;
   localparam int LIMIT_W = 16;
   localparam int CODE_W = 8;
   localparam int EDGE_W = 6;
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   localparam int FRAME_SLOTS_DEFAULT = 50;
   localparam logic [EDGE_W-1:0] FIRST_BIT_INDEX = EDGE_W'(17);
   localparam logic [EDGE_W-1:0] LAST_BIT_INDEX = EDGE_W'(24);

   localparam logic [LIMIT_W-1:0] LEADER_MIN_RESET = 16'd10000;
   localparam logic [LIMIT_W-1:0] LEADER_MAX_RESET = 16'd15000;
   localparam logic [LIMIT_W-1:0] ONE_MIN_RESET = 16'd2000;
   localparam logic [LIMIT_W-1:0] ONE_MAX_RESET = 16'd2300;

   localparam logic [1:0] REG_LEADER_MIN = 2'd0;
   localparam logic [1:0] REG_LEADER_MAX = 2'd1;
   localparam logic [1:0] REG_ONE_MIN = 2'd2;
   localparam logic [1:0] REG_ONE_MAX = 2'd3;

   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   typedef struct packed {
      logic [LIMIT_W-1:0] leader_min;
      logic [LIMIT_W-1:0] leader_max;
      logic [LIMIT_W-1:0] one_min;
      logic [LIMIT_W-1:0] one_max;
   } limits_type;

endpackage

[sv/ipd_csr.sv]
`timescale 1ns / 1ps

module ipd_csr
   import ipd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [PDATA_W-1:0] csr_pwdata,
   output logic [PDATA_W-1:0] csr_prdata,
   output logic               csr_pready,
   output limits_type         limits
);

   limits_type limits_ff;
   limits_type limits_in;
   logic [1:0] reg_sel;
   logic       wr_en;
   logic [LIMIT_W-1:0] rd_value;

   assign reg_sel = csr_paddr[3:2];
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign limits = limits_ff;

   always_comb begin
      limits_in = limits_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_LEADER_MIN: limits_in.leader_min = csr_pwdata[LIMIT_W-1:0];
            REG_LEADER_MAX: limits_in.leader_max = csr_pwdata[LIMIT_W-1:0];
            REG_ONE_MIN:    limits_in.one_min = csr_pwdata[LIMIT_W-1:0];
            REG_ONE_MAX:    limits_in.one_max = csr_pwdata[LIMIT_W-1:0];
            default:        limits_in = limits_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_LEADER_MIN: rd_value = limits_ff.leader_min;
         REG_LEADER_MAX: rd_value = limits_ff.leader_max;
         REG_ONE_MIN:    rd_value = limits_ff.one_min;
         REG_ONE_MAX:    rd_value = limits_ff.one_max;
         default:        rd_value = '0;
      endcase
   end

   assign csr_prdata = {{(PDATA_W-LIMIT_W){1'b0}}, rd_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.leader_min <= LEADER_MIN_RESET;
         limits_ff.leader_max <= LEADER_MAX_RESET;
         limits_ff.one_min <= ONE_MIN_RESET;
         limits_ff.one_max <= ONE_MAX_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

endmodule

[sv/ir_pulse_distance_command_decoder_top.sv]
`timescale 1ns / 1ps

// A timeout request passes through the input register; its command code is then
// registered in the result register. Throughput: one request per cycle while the
// result register is empty or being taken; an empty input register also takes one.
// Reset (synchronous): disarm, clear edge count, leader mark and bit marks,
// and load the default window limits.

module ir_pulse_distance_command_decoder_top
   import ipd_pkg::*;
#(
   parameter int FRAME_SLOTS = FRAME_SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [TICKS_W-1:0] req_elapsed_ticks,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CODE_W-1:0]  rsp_command_code,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [PDATA_W-1:0] csr_pwdata,
   output logic [PDATA_W-1:0] csr_prdata,
   output logic               csr_pready
);

   localparam logic [EDGE_W-1:0] SlotLimit = EDGE_W'(FRAME_SLOTS);

   limits_type limits;

   logic               req_valid_ff;
   logic               req_cmd_ff;
   logic [TICKS_W-1:0] req_ticks_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [CODE_W-1:0]  rsp_code_ff;

   logic               armed_ff;
   logic               armed_in;
   logic [EDGE_W-1:0]  edge_index_ff;
   logic [EDGE_W-1:0]  edge_index_in;
   logic               leader_ok_ff;
   logic               leader_ok_in;
   logic [CODE_W-1:0]  bit_marks_ff;
   logic [CODE_W-1:0]  bit_marks_in;

   logic               advance;
   logic               fire;
   logic [LIMIT_W-1:0] half_ticks;
   logic               leader_hit;
   logic               one_hit;
   logic [EDGE_W-1:0]  bit_offset;

   ipd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limits      (limits)
   );

   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = !req_valid_ff || advance;
   assign fire = req_valid_ff && advance;

   assign half_ticks = req_ticks_ff[TICKS_W-1:1];
   assign leader_hit = (half_ticks >= limits.leader_min) && (half_ticks <= limits.leader_max);
   assign one_hit = (half_ticks >= limits.one_min) && (half_ticks <= limits.one_max);
   assign bit_offset = edge_index_ff - FIRST_BIT_INDEX;

   always_comb begin
      armed_in = armed_ff;
      edge_index_in = edge_index_ff;
      leader_ok_in = leader_ok_ff;
      bit_marks_in = bit_marks_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire) begin
         if (req_cmd_ff == CMD_TIMEOUT) begin
            rsp_valid_in = leader_ok_ff;
            armed_in = 1'b0;
            edge_index_in = '0;
            leader_ok_in = 1'b0;
         end else if (!armed_ff) begin
            armed_in = 1'b1;
         end else if (edge_index_ff < SlotLimit) begin
            if (edge_index_ff == '0) begin
               leader_ok_in = leader_hit;
            end else if (edge_index_ff >= FIRST_BIT_INDEX &&
                         edge_index_ff <= LAST_BIT_INDEX) begin
               bit_marks_in[bit_offset[2:0]] = one_hit;
            end
            edge_index_in = edge_index_ff + EDGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         armed_ff <= 1'b0;
         edge_index_ff <= '0;
         leader_ok_ff <= 1'b0;
         bit_marks_ff <= '0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         armed_ff <= armed_in;
         edge_index_ff <= edge_index_in;
         leader_ok_ff <= leader_ok_in;
         bit_marks_ff <= bit_marks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_cmd_ff <= req_cmd;
         req_ticks_ff <= req_elapsed_ticks;
      end
      if (fire && req_cmd_ff == CMD_TIMEOUT) begin
         rsp_code_ff <= bit_marks_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_command_code = rsp_code_ff;

endmodule

[tb/ir_pulse_distance_command_decoder_top_tb.sv]
`timescale 1ns / 1ps

module ir_pulse_distance_command_decoder_top_tb;
   import ipd_pkg::*;

   localparam int SLOTS = FRAME_SLOTS_DEFAULT;

   typedef enum logic [1:0] {
      CHECK_MODEL = 2'd0,
      CHECK_NONE  = 2'd1,
      CHECK_CODE  = 2'd2
   } check_type;

   typedef struct packed {
      logic               cmd;
      logic [TICKS_W-1:0] ticks;
      check_type          check;
      logic [CODE_W-1:0]  code;
   } step_row_type;

   localparam int DIRECTED_ROWS = 20;
   localparam step_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{CMD_TIMEOUT, 17'd0,      CHECK_NONE,  8'd0},
      '{CMD_EDGE,    17'd0,      CHECK_NONE,  8'd0},
      '{CMD_EDGE,    17'd20000,  CHECK_MODEL, 8'd0},
      '{CMD_TIMEOUT, 17'd131071, CHECK_CODE,  8'd0},
      '{CMD_EDGE,    17'd131071, CHECK_NONE,  8'd0},
      '{CMD_EDGE,    17'd131071, CHECK_NONE,  8'd0},
      '{CMD_TIMEOUT, 17'd0,      CHECK_NONE,  8'd0},
      '{CMD_EDGE,    17'd12345,  CHECK_NONE,  8'd0},
      '{CMD_EDGE,    17'd30001,  CHECK_MODEL, 8'd0},
      '{CMD_TIMEOUT, 17'd0,      CHECK_CODE,  8'd0},
      '{CMD_EDGE,    17'd1,      CHECK_NONE,  8'd0},
      '{CMD_EDGE,    17'd19999,  CHECK_MODEL, 8'd0},
      '{CMD_TIMEOUT, 17'd0,      CHECK_NONE,  8'd0},
      '{CMD_EDGE,    17'd2,      CHECK_NONE,  8'd0},
      '{CMD_EDGE,    17'd30002,  CHECK_MODEL, 8'd0},
      '{CMD_TIMEOUT, 17'd0,      CHECK_NONE,  8'd0},
      '{CMD_EDGE,    17'd65535,  CHECK_NONE,  8'd0},
      '{CMD_EDGE,    17'd25000,  CHECK_MODEL, 8'd0},
      '{CMD_EDGE,    17'd4600,   CHECK_MODEL, 8'd0},
      '{CMD_TIMEOUT, 17'd0,      CHECK_CODE,  8'd0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_cmd = CMD_EDGE;
   logic [TICKS_W-1:0] req_elapsed_ticks = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [CODE_W-1:0]  rsp_command_code;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [PADDR_W-1:0] csr_paddr = '0;
   logic [PDATA_W-1:0] csr_pwdata = '0;
   logic [PDATA_W-1:0] csr_prdata;
   logic               csr_pready;

   logic               frame_armed;
   logic [EDGE_W-1:0]  edge_count;
   logic               leader_seen;
   logic [CODE_W-1:0]  code_marks;
   limits_type         limits;

   logic [CODE_W-1:0]  pending_codes [$];
   int                 error_count = 0;
   int                 requests_sent = 0;
   int                 codes_due = 0;
   bit                 calm = 1'b0;

   ir_pulse_distance_command_decoder_top #(
      .FRAME_SLOTS(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_elapsed_ticks(req_elapsed_ticks),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_command_code(rsp_command_code),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function automatic bit in_window(input logic [LIMIT_W-1:0] half,
                                    input logic [LIMIT_W-1:0] lo,
                                    input logic [LIMIT_W-1:0] hi);
      return half >= lo && half <= hi;
   endfunction

   function automatic void clear_decoder();
      frame_armed = 1'b0;
      edge_count = '0;
      leader_seen = 1'b0;
      code_marks = '0;
      limits.leader_min = LEADER_MIN_RESET;
      limits.leader_max = LEADER_MAX_RESET;
      limits.one_min = ONE_MIN_RESET;
      limits.one_max = ONE_MAX_RESET;
   endfunction

   function automatic bit decode_step(input logic cmd, input logic [TICKS_W-1:0] ticks,
                                      output logic [CODE_W-1:0] code);
      logic [LIMIT_W-1:0] half;
      logic [EDGE_W-1:0]  pos;
      bit                 emit;
      half = ticks[TICKS_W-1:1];
      emit = 1'b0;
      code = code_marks;
      if (cmd == CMD_TIMEOUT) begin
         emit = leader_seen;
         frame_armed = 1'b0;
         edge_count = '0;
         leader_seen = 1'b0;
      end else if (!frame_armed) begin
         frame_armed = 1'b1;
      end else if (edge_count < EDGE_W'(SLOTS)) begin
         if (edge_count == '0) begin
            leader_seen = in_window(half, limits.leader_min, limits.leader_max);
         end else if (edge_count >= FIRST_BIT_INDEX && edge_count <= LAST_BIT_INDEX) begin
            pos = edge_count - FIRST_BIT_INDEX;
            code_marks[pos[2:0]] = in_window(half, limits.one_min, limits.one_max);
         end
         edge_count = edge_count + 1'b1;
      end
      return emit;
   endfunction

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 28);
   end

   always @(posedge clock) begin
      logic [CODE_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            flag_error($sformatf("unexpected command code %0d", rsp_command_code));
         end else begin
            want = pending_codes.pop_front();
            if (rsp_command_code !== want) begin
               flag_error($sformatf("command code mismatch: expected %0d, got %0d",
                                    want, rsp_command_code));
            end
         end
      end
   end

   task automatic send_request(input logic cmd, input logic [TICKS_W-1:0] ticks);
      while (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_elapsed_ticks <= ticks;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   task automatic issue(input logic cmd, input logic [TICKS_W-1:0] ticks);
      logic [CODE_W-1:0] code;
      send_request(cmd, ticks);
      if (decode_step(cmd, ticks, code)) begin
         pending_codes.push_back(code);
         codes_due++;
      end
   endtask

   function automatic logic [TICKS_W-1:0] pick_ticks(input logic [LIMIT_W-1:0] lo,
                                                     input logic [LIMIT_W-1:0] hi,
                                                     input int hit_pct);
      logic [LIMIT_W-1:0] half;
      if ($urandom_range(99) < hit_pct && lo <= hi) begin
         half = LIMIT_W'($urandom_range(hi, lo));
      end else begin
         case ($urandom_range(3))
            0: half = lo - 1'b1;
            1: half = hi + 1'b1;
            2: half = lo;
            default: half = LIMIT_W'($urandom);
         endcase
      end
      return {half, 1'($urandom_range(1))};
   endfunction

   function automatic int frame_edges();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return $urandom_range(26, 24);
      if (pick < 85) return $urandom_range(23, 0);
      return $urandom_range(60, 27);
   endfunction

   task automatic start_frame(input int edges);
      issue(CMD_EDGE, TICKS_W'($urandom_range(131071)));
      issue(CMD_EDGE, pick_ticks(limits.leader_min, limits.leader_max, 85));
      repeat (edges) issue(CMD_EDGE, pick_ticks(limits.one_min, limits.one_max, 50));
   endtask

   task automatic end_frame(input int edges);
      repeat (edges) issue(CMD_EDGE, pick_ticks(limits.one_min, limits.one_max, 50));
      issue(CMD_TIMEOUT, TICKS_W'($urandom_range(131071)));
   endtask

   task automatic send_noise();
      repeat ($urandom_range(6, 1)) begin
         issue($urandom_range(99) < 30 ? CMD_TIMEOUT : CMD_EDGE,
               TICKS_W'($urandom_range(131071)));
      end
   endtask

   task automatic drain_codes();
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_limit(input logic [1:0] idx, input logic [LIMIT_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= PDATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_LEADER_MIN: limits.leader_min = value;
         REG_LEADER_MAX: limits.leader_max = value;
         REG_ONE_MIN: limits.one_min = value;
         default: limits.one_max = value;
      endcase
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[LIMIT_W-1:0] !== value) begin
         flag_error($sformatf("register %0d readback: expected %0d, got %0d",
                              idx, value, csr_prdata[LIMIT_W-1:0]));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_limits(input logic [LIMIT_W-1:0] lead_lo,
                               input logic [LIMIT_W-1:0] lead_hi,
                               input logic [LIMIT_W-1:0] one_lo,
                               input logic [LIMIT_W-1:0] one_hi);
      program_limit(REG_LEADER_MIN, lead_lo);
      program_limit(REG_LEADER_MAX, lead_hi);
      program_limit(REG_ONE_MIN, one_lo);
      program_limit(REG_ONE_MAX, one_hi);
   endtask

   task automatic phase_limits(input int phase);
      logic [LIMIT_W-1:0] lead_lo;
      logic [LIMIT_W-1:0] one_lo;
      case (phase)
         1: apply_limits(16'd0, 16'd0, 16'd0, 16'd0);
         2: apply_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         3: apply_limits(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
         4: apply_limits(LEADER_MAX_RESET, LEADER_MIN_RESET, ONE_MAX_RESET, ONE_MIN_RESET);
         5: begin
            lead_lo = LIMIT_W'($urandom_range(40000));
            one_lo = LIMIT_W'($urandom_range(60000));
            apply_limits(lead_lo, lead_lo + LIMIT_W'($urandom_range(20000)),
                         one_lo, one_lo + LIMIT_W'($urandom_range(5000)));
         end
         6: apply_limits(LIMIT_W'($urandom), LIMIT_W'($urandom),
                         LIMIT_W'($urandom), LIMIT_W'($urandom));
         default: apply_limits(LEADER_MIN_RESET, LEADER_MAX_RESET,
                               ONE_MIN_RESET, ONE_MAX_RESET);
      endcase
   endtask

   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [CODE_W-1:0] code;
      int                carry;
      int                phase_end;
      clear_decoder();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_request(DIRECTED[i].cmd, DIRECTED[i].ticks);
         if (decode_step(DIRECTED[i].cmd, DIRECTED[i].ticks, code)
             && DIRECTED[i].check == CHECK_MODEL) begin
            pending_codes.push_back(code);
         end
         if (DIRECTED[i].check == CHECK_CODE) begin
            pending_codes.push_back(DIRECTED[i].code);
         end
      end

      carry = 0;
      for (int phase = 0; phase < 8; phase++) begin
         drain_codes();
         phase_limits(phase);
         end_frame(carry);
         calm = (phase == 3);
         phase_end = requests_sent + 100;
         while (requests_sent < phase_end) begin
            if ($urandom_range(99) < 12) begin
               send_noise();
            end else begin
               start_frame(0);
               end_frame(frame_edges());
            end
         end
         carry = 0;
         if (phase < 7 && $urandom_range(1)) begin
            carry = $urandom_range(30);
            start_frame($urandom_range(20));
         end
      end
      calm = 1'b0;
      while (codes_due < 48) begin
         start_frame(0);
         end_frame(frame_edges());
      end

      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_codes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[ir_pulse_distance_command_decoder_top.f]
sv/ipd_pkg.sv
sv/ipd_csr.sv
sv/ir_pulse_distance_command_decoder_top.sv
tb/ir_pulse_distance_command_decoder_top_tb.sv
